[rtl/iee_pkg.sv]
// ----------------------------------------------------------------------------
// Expression evaluator package
// Word types, character codes and the token format shared by the front end,
// the token queue and the evaluation back end.
// ----------------------------------------------------------------------------
`default_nettype none

package iee_pkg;

  // Input word: one expression character, or the end-of-expression marker.
  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
  } iee_in_t;

  // Result word.
  typedef struct packed {
    logic signed [31:0] value;
    logic               syntax_error;
  } iee_out_t;

  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_END  = 1'b1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;

  localparam logic [31:0] NUM_BASE = 32'd10;

  typedef enum logic [2:0] {
    CLS_DIGIT = 3'd0,
    CLS_MINUS = 3'd1,
    CLS_PLUS  = 3'd2,
    CLS_STAR  = 3'd3,
    CLS_OTHER = 3'd4
  } iee_class_e;

  // Classified word as it travels from the front end to the back end.
  typedef struct packed {
    logic       end_item;
    iee_class_e cls;
    logic [3:0] digit;
  } iee_token_t;

endpackage

`default_nettype wire

[rtl/iee_front.sv]
// ----------------------------------------------------------------------------
// Expression evaluator front end
// Sorts each incoming character into digit, minus, plus, star or other and
// extracts the digit value.
// ----------------------------------------------------------------------------
`default_nettype none

module iee_front
  import iee_pkg::*;
(
  input  iee_in_t    in_word_i,
  output iee_token_t token_o
);

  iee_class_e cls;

  always_comb begin
    if (in_word_i.char_code >= CHAR_ZERO && in_word_i.char_code <= CHAR_NINE) begin
      cls = CLS_DIGIT;
    end else if (in_word_i.char_code == CHAR_MINUS) begin
      cls = CLS_MINUS;
    end else if (in_word_i.char_code == CHAR_PLUS) begin
      cls = CLS_PLUS;
    end else if (in_word_i.char_code == CHAR_STAR) begin
      cls = CLS_STAR;
    end else begin
      cls = CLS_OTHER;
    end
  end

  // The ASCII digits sit at 0x30..0x39, so the low nibble is the digit value.
  assign token_o.end_item = (in_word_i.req_type == REQ_END);
  assign token_o.cls      = cls;
  assign token_o.digit    = in_word_i.char_code[3:0];

endmodule

`default_nettype wire

[rtl/iee_queue.sv]
// ----------------------------------------------------------------------------
// Expression evaluator token queue
// Small first-in first-out buffer that decouples the front end from the
// evaluation back end.
// ----------------------------------------------------------------------------
`default_nettype none

module iee_queue
  import iee_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  input  iee_token_t push_token_i,
  output logic       full_o,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output iee_token_t pop_token_o
);

  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  iee_token_t            mem_q [Depth];
  logic [IdxW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  push, pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign pop_token_o = mem_q[rd_ptr_q];

  assign push = push_valid_i && !full_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_token_i;
    end
  end

endmodule

`default_nettype wire

[rtl/iee_back.sv]
// ----------------------------------------------------------------------------
// Expression evaluator back end
// Runs the parse automaton and the accumulators on classified tokens and
// holds the result word in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iee_back
  import iee_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tok_valid_i,
  input  iee_token_t tok_i,
  output logic       tok_ready_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output iee_out_t   out_word_o
);

  typedef enum logic [5:0] {
    ST_START = 6'b000001,
    ST_NUM   = 6'b000010,
    ST_MINUS = 6'b000100,
    ST_PLUS  = 6'b001000,
    ST_STAR  = 6'b010000,
    ST_ERR   = 6'b100000
  } parse_state_e;

  parse_state_e state_q, state_d;
  logic [31:0]  number_q, number_d;
  logic [31:0]  product_q, product_d;
  logic [31:0]  sum_q, sum_d;
  // term_q tracks number_q * product_q, updated alongside the digits, so a
  // fold into the sum needs only an add.
  logic [31:0]  term_q, term_d;
  logic         neg_q, neg_d;
  logic         out_valid_q, out_valid_d;
  iee_out_t     out_q, out_d;

  logic         out_free, take;
  logic [31:0]  signed_term, total;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign tok_ready_o = !tok_i.end_item || out_free;
  assign take        = tok_valid_i && tok_ready_o;

  assign signed_term = neg_q ? (32'd0 - term_q) : term_q;
  assign total       = sum_q + signed_term;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_START: begin
        case (tok_i.cls)
          CLS_DIGIT: state_d = ST_NUM;
          CLS_MINUS: state_d = ST_MINUS;
          CLS_PLUS:  state_d = ST_PLUS;
          default:   state_d = ST_ERR;
        endcase
      end
      ST_NUM: begin
        case (tok_i.cls)
          CLS_DIGIT: state_d = ST_NUM;
          CLS_MINUS: state_d = ST_MINUS;
          CLS_PLUS:  state_d = ST_PLUS;
          CLS_STAR:  state_d = ST_STAR;
          default:   state_d = ST_ERR;
        endcase
      end
      ST_MINUS, ST_PLUS, ST_STAR: begin
        state_d = (tok_i.cls == CLS_DIGIT) ? ST_NUM : ST_ERR;
      end
      default: state_d = ST_ERR;
    endcase
  end

  always_comb begin
    number_d    = number_q;
    product_d   = product_q;
    sum_d       = sum_q;
    term_d      = term_q;
    neg_d       = neg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (take && tok_i.end_item) begin
      out_valid_d        = 1'b1;
      out_d.syntax_error = (state_q == ST_ERR);
      out_d.value        = (state_q == ST_ERR) ? 32'sd0 : total;
      number_d           = 32'd0;
      product_d          = 32'd1;
      sum_d              = 32'd0;
      term_d             = 32'd0;
      neg_d              = 1'b0;
    end else if (take && state_q != ST_ERR) begin
      unique case (state_d)
        ST_NUM: begin
          number_d = number_q * NUM_BASE + {28'd0, tok_i.digit};
          term_d   = term_q * NUM_BASE + product_q * {28'd0, tok_i.digit};
        end
        ST_MINUS, ST_PLUS: begin
          sum_d     = total;
          product_d = 32'd1;
          number_d  = 32'd0;
          term_d    = 32'd0;
          neg_d     = (state_d == ST_MINUS);
        end
        ST_STAR: begin
          product_d = product_q * number_q;
          number_d  = 32'd0;
          term_d    = 32'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      number_q    <= 32'd0;
      product_q   <= 32'd1;
      sum_q       <= 32'd0;
      term_q      <= 32'd0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        state_q <= tok_i.end_item ? ST_START : state_d;
      end
      number_q    <= number_d;
      product_q   <= product_d;
      sum_q       <= sum_d;
      term_q      <= term_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

[rtl/infix_int_expression_evaluator.sv]
// ----------------------------------------------------------------------------
// Infix integer expression evaluator
// Evaluates a stream of ASCII characters holding an integer expression with
// +, - and *, where * binds tighter than + and -.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while in_stall_o is low: a character,
// or an end marker that returns the signed 32-bit value of the expression
// (or the syntax error flag, with value zero) and readies the block for the
// next expression. Characters produce no result word. Every word passes
// through the classifier into a QUEUE_DEPTH-word queue and is then consumed
// by the evaluation loop, which settles one word per cycle on its
// accumulator registers unless an end word waits on a held result; the
// 32x32 multiply taken on '*' is the longest path in that loop. An accepted
// end word is written into the queue and then taken by the back end, whose
// output register raises the result valid. The result word waits in that
// register, while further words keep flowing in until the queue fills.
`default_nettype none

module infix_int_expression_evaluator
  import iee_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  iee_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output iee_out_t out_word_o
);

  iee_token_t front_token;
  iee_token_t queue_token;
  logic       queue_full;
  logic       queue_valid;
  logic       back_ready;

  iee_front u_front (
    .in_word_i (in_word_i),
    .token_o   (front_token)
  );

  iee_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_token_i (front_token),
    .full_o       (queue_full),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_token_o  (queue_token)
  );

  iee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (queue_valid),
    .tok_i       (queue_token),
    .tok_ready_o (back_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  assign in_stall_o = queue_full;

endmodule

`default_nettype wire

[test/infix_int_expression_evaluator_tb.sv]
// ----------------------------------------------------------------------------
// Infix integer expression evaluator testbench
// Streams expression characters and end words into the evaluator, predicts
// each result word from its own model of the parser and accumulators, and
// compares every result word against that prediction.
// ----------------------------------------------------------------------------

// Keeps the parser and accumulator state of the expression in flight and
// the result words that end words have made due.
class expr_tracker;
  typedef enum logic [2:0] {
    PS_START,
    PS_NUMBER,
    PS_MINUS,
    PS_PLUS,
    PS_STAR,
    PS_ERROR
  } parse_state_e;

  parse_state_e state = PS_START;
  logic [31:0] number_acc = '0;
  logic [31:0] product_acc = 32'd1;
  logic [31:0] sum_acc = '0;
  logic negative = 1'b0;
  iee_pkg::iee_out_t results_due[$];
  int mismatches = 0;

  function void restart();
    state = PS_START;
    number_acc = '0;
    product_acc = 32'd1;
    sum_acc = '0;
    negative = 1'b0;
  endfunction

  function iee_pkg::iee_class_e classify(logic [7:0] c);
    if (c >= iee_pkg::CHAR_ZERO && c <= iee_pkg::CHAR_NINE) return iee_pkg::CLS_DIGIT;
    if (c == iee_pkg::CHAR_MINUS) return iee_pkg::CLS_MINUS;
    if (c == iee_pkg::CHAR_PLUS) return iee_pkg::CLS_PLUS;
    if (c == iee_pkg::CHAR_STAR) return iee_pkg::CLS_STAR;
    return iee_pkg::CLS_OTHER;
  endfunction

  function parse_state_e advance(parse_state_e s, iee_pkg::iee_class_e cls);
    case (s)
      PS_START: begin
        case (cls)
          iee_pkg::CLS_DIGIT: return PS_NUMBER;
          iee_pkg::CLS_MINUS: return PS_MINUS;
          iee_pkg::CLS_PLUS:  return PS_PLUS;
          default:            return PS_ERROR;
        endcase
      end
      PS_NUMBER: begin
        case (cls)
          iee_pkg::CLS_DIGIT: return PS_NUMBER;
          iee_pkg::CLS_MINUS: return PS_MINUS;
          iee_pkg::CLS_PLUS:  return PS_PLUS;
          iee_pkg::CLS_STAR:  return PS_STAR;
          default:            return PS_ERROR;
        endcase
      end
      PS_MINUS, PS_PLUS, PS_STAR: begin
        return (cls == iee_pkg::CLS_DIGIT) ? PS_NUMBER : PS_ERROR;
      end
      default: return PS_ERROR;
    endcase
  endfunction

  function logic [31:0] signed_term();
    logic [31:0] t;
    t = number_acc * product_acc;
    return negative ? 32'd0 - t : t;
  endfunction

  function void note_word(iee_pkg::iee_in_t w);
    iee_pkg::iee_out_t res;
    if (w.req_type == iee_pkg::REQ_END) begin
      if (state == PS_ERROR) begin
        res.value = '0;
        res.syntax_error = 1'b1;
      end else begin
        res.value = sum_acc + signed_term();
        res.syntax_error = 1'b0;
      end
      results_due.push_back(res);
      restart();
      return;
    end
    // Once the parser has failed, characters are dropped until the end word.
    if (state == PS_ERROR) return;
    state = advance(state, classify(w.char_code));
    case (state)
      PS_NUMBER: begin
        number_acc = number_acc * iee_pkg::NUM_BASE + 32'(w.char_code - iee_pkg::CHAR_ZERO);
      end
      PS_MINUS, PS_PLUS: begin
        sum_acc = sum_acc + signed_term();
        product_acc = 32'd1;
        number_acc = '0;
        negative = (state == PS_MINUS);
      end
      PS_STAR: begin
        product_acc = product_acc * number_acc;
        number_acc = '0;
      end
      default: ;
    endcase
  endfunction

  function void check_result(iee_pkg::iee_out_t got);
    iee_pkg::iee_out_t want;
    if (results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: value %0d error %0b",
                 $signed(got.value), got.syntax_error);
      return;
    end
    want = results_due.pop_front();
    if (got.value !== want.value || got.syntax_error !== want.syntax_error) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected value %0d error %0b, got value %0d error %0b",
                 $signed(want.value), want.syntax_error,
                 $signed(got.value), got.syntax_error);
    end
  endfunction

  function int pending();
    return results_due.size();
  endfunction
endclass

module infix_int_expression_evaluator_tb;
  import iee_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1950;
  localparam int CALM_TAIL   = 250;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall_o;
  iee_in_t  in_word = '0;
  logic     out_valid_o;
  logic     out_stall = 1'b0;
  iee_out_t out_word_o;

  expr_tracker tracker;
  logic [7:0]  expr_chars[$];
  int          words_sent = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b0;
  bit          calm = 1'b0;
  bit          paused_once = 1'b0;

  infix_int_expression_evaluator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL infix_int_expression_evaluator");
    $finish;
  end

  // Result side: check each accepted word, then decide whether to stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) tracker.check_result(out_word_o);
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Presents one word and returns at the edge that accepts it. Valid is
  // left high so that back-to-back words keep it up without a glitch.
  task automatic send_word(input iee_in_t w);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_word(w);
    words_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    iee_in_t w;
    w.req_type = REQ_CHAR;
    w.char_code = c;
    send_word(w);
  endtask

  task automatic send_end();
    iee_in_t w;
    w.req_type = REQ_END;
    w.char_code = 8'($urandom_range(0, 255));
    send_word(w);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  // Holds the sender off until every due result word has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 2))
      0:       return CHAR_MINUS;
      1:       return CHAR_PLUS;
      default: return CHAR_STAR;
    endcase
  endfunction

  // Mostly well-formed expressions with random numbers and operators; some
  // get a stray character inserted, and a few are pure byte noise.
  task automatic build_random_expr();
    int kind;
    int terms;
    int digits;
    int pos;
    int t;
    logic [7:0] junk;
    expr_chars.delete();
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 8)) expr_chars.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 3))
      0:       expr_chars.push_back(CHAR_MINUS);
      1:       expr_chars.push_back(CHAR_PLUS);
      default: ;
    endcase
    terms = $urandom_range(1, 5);
    for (t = 0; t < terms; t++) begin
      // Long numbers make the accumulators and products wrap.
      digits = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      repeat (digits) expr_chars.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      if (t < terms - 1 || $urandom_range(0, 5) == 0) expr_chars.push_back(random_operator());
    end
    if (kind >= 7) begin
      pos = $urandom_range(0, expr_chars.size());
      junk = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255)) : random_operator();
      expr_chars.insert(pos, junk);
    end
  endtask

  initial begin
    tracker = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;

    // Empty expression, leading signs, trailing operators, digit extremes,
    // an operator in the start state, a NUL followed by a digit that must be
    // ignored, an all-ones code, and precedence of multiplication.
    send_end();
    send_text("-9*");
    send_end();
    send_text("+0+");
    send_end();
    send_text("*");
    send_end();
    send_char(8'h00);
    send_char(CHAR_NINE);
    send_end();
    send_text("8");
    send_char(8'hFF);
    send_end();
    send_text("7*3-2");
    send_end();
    wait_for_results();

    while (words_sent < ITEM_TARGET) begin
      if (!paused_once && words_sent >= ITEM_TARGET / 2) begin
        wait_for_results();
        paused_once = 1'b1;
      end
      calm = (words_sent >= ITEM_TARGET - CALM_TAIL);
      idle_on = !calm && ($urandom_range(0, 3) != 0);
      build_random_expr();
      foreach (expr_chars[i]) send_char(expr_chars[i]);
      send_end();
    end
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASS infix_int_expression_evaluator");
    end else begin
      $display("FAIL infix_int_expression_evaluator");
    end
    $finish;
  end

endmodule
